// ===== src/sasmd_pkg.sv =====
// ----------------------------------------------------------------------------
// sasmd_pkg
// Mode codes and controller/datapath interface types for the signed
// add/sub/mul/div unit.
// ----------------------------------------------------------------------------
package sasmd_pkg;

    localparam int MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NEG = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ABS = 3'd5;

    typedef struct packed {
        logic load;      // capture operands of an accepted transaction
        logic step;      // one shift-add / shift-subtract iteration
        logic out_load;  // move final result into the output register
    } sasmd_cmd_t;

    typedef struct packed {
        logic iter_active;  // iterations remain
        logic iter_last;    // current iteration is the final one
        logic out_busy;     // output register holds an untaken result
    } sasmd_status_t;

endpackage

// ===== src/sasmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sasmd_ctrl
// Sequencer: accepts a transaction, runs the datapath iterations, then hands
// the result to the output register once it is free.
// ----------------------------------------------------------------------------
module sasmd_ctrl
    import sasmd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sasmd_status_t status,
    output sasmd_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.step = status.iter_active;
                if (!status.iter_active || status.iter_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/sasmd_datapath.sv =====
// ----------------------------------------------------------------------------
// sasmd_datapath
// Operand registers, shared shift-add multiply / restoring divide iteration,
// sign restore and the output register.
// ----------------------------------------------------------------------------
module sasmd_datapath
    import sasmd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sasmd_cmd_t                   cmd,
    output sasmd_status_t                status,
    input  logic [MODE_W-1:0]            s_mode,
    input  logic signed [DATA_WIDTH-1:0] s_operand_a,
    input  logic signed [DATA_WIDTH-1:0] s_operand_b,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_value,
    output logic                         m_divide_by_zero
);

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    logic [MODE_W-1:0]     mode_reg;
    logic [DATA_WIDTH-1:0] a_reg;
    logic [DATA_WIDTH-1:0] b_reg;
    logic                  neg_reg;
    logic [DATA_WIDTH-1:0] x_reg;     // multiplicand / dividend-quotient
    logic [DATA_WIDTH-1:0] y_reg;     // multiplier / divisor
    logic [DATA_WIDTH:0]   acc_reg;   // product / partial remainder
    logic [CNT_W-1:0]      cnt_reg;
    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic                  dz_reg;

    logic [DATA_WIDTH-1:0] in_a;
    logic [DATA_WIDTH-1:0] in_b;
    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_b;
    logic                  in_iter;

    logic [DATA_WIDTH:0]   mul_sum;
    logic [DATA_WIDTH:0]   div_shift;
    logic [DATA_WIDTH:0]   div_diff;

    logic [DATA_WIDTH-1:0] unsigned_res;
    logic [DATA_WIDTH-1:0] result;
    logic                  result_dz;

    assign in_a    = s_operand_a;
    assign in_b    = s_operand_b;
    assign mag_a   = in_a[DATA_WIDTH-1] ? (~in_a + 1'b1) : in_a;
    assign mag_b   = in_b[DATA_WIDTH-1] ? (~in_b + 1'b1) : in_b;
    assign in_iter = (s_mode == MODE_MUL) || ((s_mode == MODE_DIV) && (in_b != '0));

    assign mul_sum   = acc_reg + (y_reg[0] ? {1'b0, x_reg} : '0);
    assign div_shift = {acc_reg[DATA_WIDTH-1:0], x_reg[DATA_WIDTH-1]};
    assign div_diff  = div_shift - {1'b0, y_reg};

    always_comb begin
        unsigned_res = (mode_reg == MODE_MUL) ? acc_reg[DATA_WIDTH-1:0] : x_reg;
        result       = '0;
        result_dz    = 1'b0;
        case (mode_reg)
            MODE_ADD: result = a_reg + b_reg;
            MODE_SUB: result = a_reg - b_reg;
            MODE_MUL, MODE_DIV: begin
                if ((mode_reg == MODE_DIV) && (b_reg == '0)) begin
                    result_dz = 1'b1;
                end else begin
                    result = neg_reg ? (~unsigned_res + 1'b1) : unsigned_res;
                end
            end
            MODE_NEG: result = ~a_reg + 1'b1;
            MODE_ABS: result = a_reg[DATA_WIDTH-1] ? (~a_reg + 1'b1) : a_reg;
            default:  result = '0;
        endcase
    end

    assign status.iter_active = (cnt_reg != '0);
    assign status.iter_last   = (cnt_reg == CNT_W'(1));
    assign status.out_busy    = valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= s_mode;
            a_reg    <= in_a;
            b_reg    <= in_b;
            neg_reg  <= in_a[DATA_WIDTH-1] ^ in_b[DATA_WIDTH-1];
            x_reg    <= mag_a;
            y_reg    <= mag_b;
            acc_reg  <= '0;
        end else if (cmd.step) begin
            if (mode_reg == MODE_MUL) begin
                acc_reg <= mul_sum;
                x_reg   <= {x_reg[DATA_WIDTH-2:0], 1'b0};
                y_reg   <= {1'b0, y_reg[DATA_WIDTH-1:1]};
            end else begin
                if (!div_diff[DATA_WIDTH]) begin
                    acc_reg <= div_diff;
                    x_reg   <= {x_reg[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    acc_reg <= div_shift;
                    x_reg   <= {x_reg[DATA_WIDTH-2:0], 1'b0};
                end
            end
        end
        if (cmd.out_load) begin
            value_reg <= result;
            dz_reg    <= result_dz;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                cnt_reg <= in_iter ? CNT_W'(DATA_WIDTH) : '0;
            end else if (cmd.step) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.out_load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = valid_reg;
    assign m_value          = value_reg;
    assign m_divide_by_zero = dz_reg;

endmodule

// ===== src/signed_add_sub_mul_div_unit.sv =====
// Signed integer arithmetic unit: add, subtract, multiply (low word of the
// signed product), divide (quotient truncated toward zero, flagged and 0 on a
// zero divisor), negate and absolute value, all wrapping at DATA_WIDTH bits.
// One transaction is processed at a time. Add, subtract, negate, absolute
// value, unused modes and divide by zero pass through the run and finish
// states without iterating before the result register is loaded; multiply
// and divide iterate over every operand bit in the run state, in the single
// shared shift-add / shift-subtract unit that retires one operand bit per
// cycle. The next transaction is accepted in the cycle after the result is
// loaded. A new transaction is accepted while the previous result still
// waits in the output register; its own result then waits in the sequencer
// until the output register is taken.
// ----------------------------------------------------------------------------
// signed_add_sub_mul_div_unit
// Top level: sequencer plus iterative arithmetic datapath.
// ----------------------------------------------------------------------------
module signed_add_sub_mul_div_unit
    import sasmd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [MODE_W-1:0]            s_mode,
    input  logic signed [DATA_WIDTH-1:0] s_operand_a,
    input  logic signed [DATA_WIDTH-1:0] s_operand_b,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_value,
    output logic                         m_divide_by_zero
);

    sasmd_cmd_t    cmd;
    sasmd_status_t status;

    sasmd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sasmd_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_mode           (s_mode),
        .s_operand_a      (s_operand_a),
        .s_operand_b      (s_operand_b),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_value          (m_value),
        .m_divide_by_zero (m_divide_by_zero)
    );

    // one transaction in flight
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a transaction is in flight");

    // a new result lands only as the sequencer returns to idle
    a_result_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result loaded without returning to idle");

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_divide_by_zero) |-> (m_value == '0))
        else $error("divide by zero result not zero");

endmodule
